// ===== rtl/core/pqs_pkg.sv =====
// ----------------------------------------------------------------------------
// pqs_pkg
// Shared types and codes for the process queue scheduler.
// ----------------------------------------------------------------------------
package pqs_pkg;

    localparam logic [3:0] KIND_CREATE   = 4'd0;
    localparam logic [3:0] KIND_BLOCK    = 4'd1;
    localparam logic [3:0] KIND_UNBLOCK  = 4'd2;
    localparam logic [3:0] KIND_SUSPEND  = 4'd3;
    localparam logic [3:0] KIND_RESUME   = 4'd4;
    localparam logic [3:0] KIND_SET_PRIO = 4'd5;
    localparam logic [3:0] KIND_QUERY    = 4'd6;
    localparam logic [3:0] KIND_DEQUEUE  = 4'd7;
    localparam logic [3:0] KIND_REQUEUE  = 4'd8;
    localparam logic [3:0] KIND_CLEAR    = 4'd9;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_EMPTY     = 3'd2;
    localparam logic [2:0] ST_EXISTS    = 3'd3;
    localparam logic [2:0] ST_QUEUED    = 3'd4;

    localparam logic [1:0] Q_READY     = 2'd0;
    localparam logic [1:0] Q_BLOCKED   = 2'd1;
    localparam logic [1:0] Q_SUSP_RDY  = 2'd2;
    localparam logic [1:0] Q_SUSP_BLK  = 2'd3;

    typedef enum logic [3:0] {
        OP_CREATE, OP_BLOCK, OP_UNBLOCK, OP_SUSPEND, OP_RESUME, OP_SET_PRIO,
        OP_QUERY, OP_DEQUEUE, OP_REQUEUE, OP_CLEAR, OP_NONE
    } t_op;

    typedef struct packed {
        t_op        op;
        logic       id_ok;
        logic [3:0] id;
        logic [3:0] prio;
        logic [3:0] cls;
        logic [1:0] sel;
    } t_cmd;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] id;
        logic [3:0] prio;
        logic [3:0] cls;
        logic       blocked;
        logic       suspended;
        logic [4:0] count;
    } t_res;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_UNL1, S_UNL2, S_INS, S_WALK,
        S_AT1, S_AT2, S_TAIL1, S_TAIL2, S_DONE
    } t_state;

    function automatic logic [1:0] home_q(input logic blk, input logic sus);
        logic [1:0] q;
        if (sus) q = blk ? Q_SUSP_BLK : Q_SUSP_RDY;
        else     q = blk ? Q_BLOCKED : Q_READY;
        return q;
    endfunction

endpackage

// ===== rtl/core/pqs_front.sv =====
// ----------------------------------------------------------------------------
// pqs_front
// Accepts items, decodes the kind and id range, and buffers them in a
// two-deep command queue for the back end.
// ----------------------------------------------------------------------------
module pqs_front import pqs_pkg::*; #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_kind,
    input  logic [3:0]  i_process_id,
    input  logic [3:0]  i_new_priority,
    input  logic [3:0]  i_process_class,
    input  logic [1:0]  i_queue_select,
    output logic        o_cmd_valid,
    input  logic        i_cmd_ready,
    output t_cmd        o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_cmd       cmd;
    logic       push;
    logic       pop;

    always_comb begin
        case (i_kind)
            KIND_CREATE:   cmd.op = OP_CREATE;
            KIND_BLOCK:    cmd.op = OP_BLOCK;
            KIND_UNBLOCK:  cmd.op = OP_UNBLOCK;
            KIND_SUSPEND:  cmd.op = OP_SUSPEND;
            KIND_RESUME:   cmd.op = OP_RESUME;
            KIND_SET_PRIO: cmd.op = OP_SET_PRIO;
            KIND_QUERY:    cmd.op = OP_QUERY;
            KIND_DEQUEUE:  cmd.op = OP_DEQUEUE;
            KIND_REQUEUE:  cmd.op = OP_REQUEUE;
            KIND_CLEAR:    cmd.op = OP_CLEAR;
            default:       cmd.op = OP_NONE;
        endcase
        cmd.id_ok = (32'(i_process_id) < MAX_ENTRIES);
        cmd.id    = i_process_id;
        cmd.prio  = i_new_priority;
        cmd.cls   = i_process_class;
        cmd.sel   = i_queue_select;
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_mem[r_rp];
    assign push        = i_valid && o_ready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= cmd;
    end

endmodule

// ===== rtl/core/pqs_back.sv =====
// ----------------------------------------------------------------------------
// pqs_back
// Process table and linked queues. A sequencer carries out one command at a
// time with one entry read and one write per link array in each cycle.
// ----------------------------------------------------------------------------
module pqs_back import pqs_pkg::*; #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_cmd_valid,
    output logic  o_cmd_ready,
    input  t_cmd  i_cmd,
    output logic  o_res_valid,
    input  logic  i_res_ready,
    output t_res  o_res
);

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int LW = $clog2(MAX_ENTRIES + 1);
    localparam logic [LW-1:0] NIL = LW'(MAX_ENTRIES);

    // entry table
    logic [3:0]    r_e_prio  [MAX_ENTRIES];
    logic [3:0]    r_e_cls   [MAX_ENTRIES];
    logic          r_e_blk   [MAX_ENTRIES];
    logic          r_e_sus   [MAX_ENTRIES];
    logic [LW-1:0] r_l_next  [MAX_ENTRIES];
    logic [LW-1:0] r_l_prev  [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] r_valid;
    logic [MAX_ENTRIES-1:0] r_queued;
    logic [LW-1:0] r_head [4];
    logic [LW-1:0] r_tail [4];
    logic [LW-1:0] r_size [4];

    t_state        r_state, n_state;
    t_cmd          r_cmd;
    logic [IW-1:0] r_id, n_id;
    logic [3:0]    r_prio, n_prio, r_cls, n_cls;
    logic          r_blk, n_blk, r_sus, n_sus;
    logic [LW-1:0] r_prev, n_prev, r_next, n_next, r_cur, n_cur;
    logic [1:0]    r_q, n_q;
    logic [2:0]    r_status, n_status;
    logic          r_rep, n_rep;
    t_res          r_res;
    logic          r_res_valid;

    logic [IW-1:0] rd_addr;
    logic [3:0]    rd_prio, rd_cls;
    logic          rd_blk, rd_sus;
    logic [LW-1:0] rd_prev, rd_next;

    logic          ln_we, lp_we, ent_we, val_set, q_set, q_clr, clr_all;
    logic [IW-1:0] ln_a, lp_a, ent_a;
    logic [LW-1:0] ln_d, lp_d;
    logic          hd_we, tl_we, sz_inc, sz_dec, res_load;
    logic [LW-1:0] hd_d;
    logic [LW-1:0] id_link;
    logic          exists, linked;
    logic [IW-1:0] cmd_idx;
    logic [31:0]   cnt_wide;

    assign rd_prio = r_e_prio[rd_addr];
    assign rd_cls  = r_e_cls[rd_addr];
    assign rd_blk  = r_e_blk[rd_addr];
    assign rd_sus  = r_e_sus[rd_addr];
    assign rd_prev = r_l_prev[rd_addr];
    assign rd_next = r_l_next[rd_addr];

    assign cmd_idx = IW'(r_cmd.id);
    assign exists  = r_cmd.id_ok && r_valid[cmd_idx];
    assign linked  = exists && r_queued[cmd_idx];
    assign id_link = LW'(r_id);

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    always_comb begin
        n_state = r_state;
        n_id = r_id; n_prio = r_prio; n_cls = r_cls; n_blk = r_blk; n_sus = r_sus;
        n_prev = r_prev; n_next = r_next; n_cur = r_cur; n_q = r_q;
        n_status = r_status; n_rep = r_rep;
        rd_addr = cmd_idx;
        ln_we = 1'b0; ln_a = r_id; ln_d = NIL;
        lp_we = 1'b0; lp_a = r_id; lp_d = NIL;
        ent_we = 1'b0; ent_a = r_id; val_set = 1'b0;
        q_set = 1'b0; q_clr = 1'b0; clr_all = 1'b0;
        hd_we = 1'b0; hd_d = id_link; tl_we = 1'b0;
        sz_inc = 1'b0; sz_dec = 1'b0; res_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                n_status = ST_OK;
                n_rep    = 1'b0;
                n_state  = S_DONE;
                if (r_cmd.op == OP_DEQUEUE) rd_addr = IW'(r_head[r_cmd.sel]);
                n_id = rd_addr;
                n_prio = rd_prio; n_cls = rd_cls; n_blk = rd_blk; n_sus = rd_sus;
                n_prev = rd_prev; n_next = rd_next;
                n_q = home_q(rd_blk, rd_sus);
                case (r_cmd.op)
                    OP_CREATE: begin
                        if (!r_cmd.id_ok) n_status = ST_NOT_FOUND;
                        else if (exists) begin
                            n_status = ST_EXISTS;
                            n_rep    = 1'b1;
                        end else begin
                            n_prio = r_cmd.prio; n_cls = r_cmd.cls;
                            n_blk = 1'b0; n_sus = 1'b0;
                            ent_we = 1'b1; ent_a = cmd_idx; val_set = 1'b1;
                            n_rep = 1'b1;
                            n_state = S_INS;
                        end
                    end
                    OP_BLOCK, OP_UNBLOCK, OP_SUSPEND, OP_RESUME, OP_SET_PRIO: begin
                        if (!linked) n_status = ST_NOT_FOUND;
                        else begin
                            n_rep = 1'b1;
                            n_state = S_UNL1;
                        end
                    end
                    OP_QUERY: begin
                        if (!exists) n_status = ST_NOT_FOUND;
                        else n_rep = 1'b1;
                    end
                    OP_DEQUEUE: begin
                        if (r_head[r_cmd.sel] == NIL) n_status = ST_EMPTY;
                        else begin
                            n_q = r_cmd.sel;
                            n_rep = 1'b1;
                            n_state = S_UNL1;
                        end
                    end
                    OP_REQUEUE: begin
                        if (!exists) n_status = ST_NOT_FOUND;
                        else if (linked) begin
                            n_status = ST_QUEUED;
                            n_rep = 1'b1;
                        end else begin
                            n_rep = 1'b1;
                            n_state = S_INS;
                        end
                    end
                    OP_CLEAR: clr_all = 1'b1;
                    default: ;
                endcase
            end
            S_UNL1: begin
                if (r_prev != NIL) begin
                    ln_we = 1'b1; ln_a = IW'(r_prev); ln_d = r_next;
                end else begin
                    hd_we = 1'b1; hd_d = r_next;
                end
                n_state = S_UNL2;
            end
            S_UNL2: begin
                if (r_next != NIL) begin
                    lp_we = 1'b1; lp_a = IW'(r_next); lp_d = r_prev;
                end else begin
                    tl_we = 1'b1;
                end
                sz_dec = 1'b1;
                q_clr  = 1'b1;
                case (r_cmd.op)
                    OP_BLOCK:    n_blk = 1'b1;
                    OP_UNBLOCK:  n_blk = 1'b0;
                    OP_SUSPEND:  n_sus = 1'b1;
                    OP_RESUME:   n_sus = 1'b0;
                    OP_SET_PRIO: n_prio = r_cmd.prio;
                    default: ;
                endcase
                ent_we  = (r_cmd.op != OP_DEQUEUE);
                n_state = (r_cmd.op == OP_DEQUEUE) ? S_DONE : S_INS;
            end
            S_INS: begin
                n_q = home_q(r_blk, r_sus);
                n_cur = r_head[Q_READY];
                n_state = (home_q(r_blk, r_sus) == Q_READY) ? S_WALK : S_TAIL1;
            end
            S_WALK: begin
                // stable order: pass every entry of equal or lower priority
                rd_addr = IW'(r_cur);
                if (r_cur == NIL) n_state = S_TAIL1;
                else if (rd_prio <= r_prio) n_cur = rd_next;
                else begin
                    n_prev = rd_prev;
                    n_state = S_AT1;
                end
            end
            S_AT1: begin
                ln_we = 1'b1; ln_d = r_cur;
                lp_we = 1'b1; lp_d = r_prev;
                n_state = S_AT2;
            end
            S_AT2: begin
                lp_we = 1'b1; lp_a = IW'(r_cur); lp_d = id_link;
                if (r_prev != NIL) begin
                    ln_we = 1'b1; ln_a = IW'(r_prev); ln_d = id_link;
                end else hd_we = 1'b1;
                sz_inc = 1'b1; q_set = 1'b1;
                n_state = S_DONE;
            end
            S_TAIL1: begin
                n_prev = r_tail[r_q];
                lp_we = 1'b1; lp_d = r_tail[r_q];
                ln_we = 1'b1; ln_d = NIL;
                n_state = S_TAIL2;
            end
            S_TAIL2: begin
                if (r_prev != NIL) begin
                    ln_we = 1'b1; ln_a = IW'(r_prev); ln_d = id_link;
                end else hd_we = 1'b1;
                tl_we = 1'b1;
                sz_inc = 1'b1; q_set = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_res_valid || i_res_ready) begin
                    res_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign cnt_wide = 32'(r_size[r_cmd.sel]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_queued    <= '0;
            r_res_valid <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                r_head[k] <= NIL;
                r_tail[k] <= NIL;
                r_size[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (res_load) r_res_valid <= 1'b1;
            else if (i_res_ready) r_res_valid <= 1'b0;
            if (clr_all) begin
                r_valid  <= '0;
                r_queued <= '0;
                for (int k = 0; k < 4; k++) begin
                    r_head[k] <= NIL;
                    r_tail[k] <= NIL;
                    r_size[k] <= '0;
                end
            end else begin
                if (val_set) r_valid[ent_a] <= 1'b1;
                if (q_set)   r_queued[r_id] <= 1'b1;
                if (q_clr)   r_queued[r_id] <= 1'b0;
                if (hd_we)   r_head[r_q] <= hd_d;
                if (tl_we)   r_tail[r_q] <= (r_state == S_UNL2) ? r_prev : id_link;
                if (sz_inc)  r_size[r_q] <= r_size[r_q] + 1'b1;
                if (sz_dec && r_size[r_q] != '0) r_size[r_q] <= r_size[r_q] - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_valid && r_state == S_IDLE) r_cmd <= i_cmd;
        r_id <= n_id; r_prio <= n_prio; r_cls <= n_cls; r_blk <= n_blk; r_sus <= n_sus;
        r_prev <= n_prev; r_next <= n_next; r_cur <= n_cur; r_q <= n_q;
        r_status <= n_status; r_rep <= n_rep;
        if (ent_we) begin
            r_e_prio[ent_a] <= n_prio;
            r_e_cls[ent_a]  <= n_cls;
            r_e_blk[ent_a]  <= n_blk;
            r_e_sus[ent_a]  <= n_sus;
        end
        if (ln_we) r_l_next[ln_a] <= ln_d;
        if (lp_we) r_l_prev[lp_a] <= lp_d;
        if (res_load) begin
            r_res.status    <= r_status;
            r_res.id        <= r_rep ? 4'(r_id) : 4'd0;
            r_res.prio      <= r_rep ? r_prio : 4'd0;
            r_res.cls       <= r_rep ? r_cls : 4'd0;
            r_res.blocked   <= r_rep & r_blk;
            r_res.suspended <= r_rep & r_sus;
            r_res.count     <= cnt_wide[4:0];
        end
    end

endmodule

// ===== rtl/core/process_queue_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// process_queue_scheduler_unit
// Process table with a priority-ordered ready queue and three FIFO queues.
// ----------------------------------------------------------------------------
// One item is handled at a time. An insert into the ready queue walks it one
// entry per cycle, so an item takes longer the more ready-queue entries it passes.
// A two-deep command queue takes new items while one is being handled, and
// the result register holds a finished result until it is taken.
module process_queue_scheduler_unit import pqs_pkg::*; #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // kind[3:0], process_id[7:4], new_priority[11:8], process_class[15:12],
    // queue_select[17:16], zero[23:18]
    input  logic [23:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // status[2:0], out_id[6:3], out_priority[10:7], out_class[14:11],
    // out_blocked[15], out_suspended[16], queue_count[21:17], zero[23:22]
    output logic [23:0] o_m_tdata
);

    logic cmd_valid, cmd_ready;
    t_cmd cmd;
    t_res res;

    pqs_front #(.MAX_ENTRIES(MAX_ENTRIES)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_s_tvalid),
        .o_ready         (o_s_tready),
        .i_kind          (i_s_tdata[3:0]),
        .i_process_id    (i_s_tdata[7:4]),
        .i_new_priority  (i_s_tdata[11:8]),
        .i_process_class (i_s_tdata[15:12]),
        .i_queue_select  (i_s_tdata[17:16]),
        .o_cmd_valid     (cmd_valid),
        .i_cmd_ready     (cmd_ready),
        .o_cmd           (cmd)
    );

    pqs_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_res_valid (o_m_tvalid),
        .i_res_ready (i_m_tready),
        .o_res       (res)
    );

    assign o_m_tdata = {2'b00, res.count, res.suspended, res.blocked, res.cls,
                        res.prio, res.id, res.status};

endmodule

// ===== test/process_queue_scheduler_unit_test.sv =====
// ----------------------------------------------------------------------------
// process_queue_scheduler_unit_test
// Self-checking bench for the process queue scheduler. Items are built from
// directed and random command sequences. Each item's result is predicted from
// a behavioral copy of the process table and its four linked queues, then
// compared field by field with what comes out of the block. Both stream sides
// idle at random, and the output side holds off for one long stretch.
// ----------------------------------------------------------------------------
module process_queue_scheduler_unit_test;
    import pqs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_PROCS   = 16;
    localparam int NIL_LINK    = NUM_PROCS;
    localparam int WATCH_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [3:0] kind;
        logic [3:0] pid;
        logic [3:0] prio;
        logic [3:0] cls;
        logic [1:0] sel;
    } t_sched_cmd;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    // kind[3:0], process_id[7:4], new_priority[11:8], process_class[15:12],
    // queue_select[17:16], zero[23:18]
    logic [23:0] i_s_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready;
    // status[2:0], out_id[6:3], out_priority[10:7], out_class[14:11],
    // out_blocked[15], out_suspended[16], queue_count[21:17], zero[23:22]
    logic [23:0] o_m_tdata;

    process_queue_scheduler_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // shadow process table
    bit       pt_valid   [NUM_PROCS];
    bit       pt_queued  [NUM_PROCS];
    bit [3:0] pt_prio    [NUM_PROCS];
    bit [3:0] pt_cls     [NUM_PROCS];
    bit       pt_blk     [NUM_PROCS];
    bit       pt_sus     [NUM_PROCS];
    int       pt_next    [NUM_PROCS];
    int       pt_prev    [NUM_PROCS];
    int       q_head     [4];
    int       q_tail     [4];
    int       q_size     [4];

    t_sched_cmd cmd_q[$];
    t_res       expected_results[$];
    int         errors;
    bit         stim_done;
    bit         quiet_phase;
    bit         hold_req;
    int         hold_cnt;
    int         idle_watch;

    function automatic int queue_of(int id);
        if (pt_sus[id]) return pt_blk[id] ? 3 : 2;
        return pt_blk[id] ? 1 : 0;
    endfunction

    function automatic void sched_unlink(int id);
        int q;
        int p;
        int n;
        q = queue_of(id);
        p = pt_prev[id];
        n = pt_next[id];
        if (p < NIL_LINK) pt_next[p] = n; else q_head[q] = n;
        if (n < NIL_LINK) pt_prev[n] = p; else q_tail[q] = p;
        pt_next[id] = NIL_LINK;
        pt_prev[id] = NIL_LINK;
        if (q_size[q] > 0) q_size[q]--;
        pt_queued[id] = 0;
    endfunction

    function automatic void sched_insert(int id);
        int q;
        int at;
        int cur;
        int steps;
        int p;
        int t;
        q = queue_of(id);
        at = NIL_LINK;
        if (q == 0) begin
            // ready queue: go behind all entries of equal or lower priority
            cur = q_head[0];
            steps = 0;
            while (cur < NIL_LINK && steps < NUM_PROCS && pt_prio[cur] <= pt_prio[id]) begin
                cur = pt_next[cur];
                steps++;
            end
            at = cur;
        end
        if (at >= NIL_LINK) begin
            t = q_tail[q];
            pt_prev[id] = t;
            pt_next[id] = NIL_LINK;
            if (t < NIL_LINK) pt_next[t] = id; else q_head[q] = id;
            q_tail[q] = id;
        end else begin
            p = pt_prev[at];
            pt_prev[id] = p;
            pt_next[id] = at;
            pt_prev[at] = id;
            if (p < NIL_LINK) pt_next[p] = id; else q_head[q] = id;
        end
        q_size[q]++;
        pt_queued[id] = 1;
    endfunction

    function automatic void sched_reset();
        for (int i = 0; i < NUM_PROCS; i++) begin
            pt_valid[i] = 0; pt_queued[i] = 0; pt_prio[i] = 0; pt_cls[i] = 0;
            pt_blk[i] = 0; pt_sus[i] = 0; pt_next[i] = 0; pt_prev[i] = 0;
        end
        for (int i = 0; i < 4; i++) begin
            q_head[i] = NIL_LINK; q_tail[i] = NIL_LINK; q_size[i] = 0;
        end
    endfunction

    function automatic t_res entry_fields(int id);
        t_res r;
        r = '0;
        r.id = id[3:0];
        r.prio = pt_prio[id];
        r.cls = pt_cls[id];
        r.blocked = pt_blk[id];
        r.suspended = pt_sus[id];
        return r;
    endfunction

    function automatic t_res sched_apply(t_sched_cmd c);
        t_res r;
        int id;
        int h;
        bit present;
        bit linked;
        r = '0;
        id = int'(c.pid);
        present = pt_valid[id];
        linked = present && pt_queued[id];
        r.status = ST_OK;
        case (c.kind)
            KIND_CREATE: begin
                if (present) begin
                    r = entry_fields(id);
                    r.status = ST_EXISTS;
                end else begin
                    pt_valid[id] = 1; pt_prio[id] = c.prio; pt_cls[id] = c.cls;
                    pt_blk[id] = 0; pt_sus[id] = 0;
                    sched_insert(id);
                    r = entry_fields(id);
                end
            end
            KIND_BLOCK, KIND_UNBLOCK, KIND_SUSPEND, KIND_RESUME, KIND_SET_PRIO: begin
                if (!linked) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    sched_unlink(id);
                    case (c.kind)
                        KIND_BLOCK:   pt_blk[id] = 1;
                        KIND_UNBLOCK: pt_blk[id] = 0;
                        KIND_SUSPEND: pt_sus[id] = 1;
                        KIND_RESUME:  pt_sus[id] = 0;
                        default:      pt_prio[id] = c.prio;
                    endcase
                    sched_insert(id);
                    r = entry_fields(id);
                end
            end
            KIND_QUERY: begin
                if (present) r = entry_fields(id); else r.status = ST_NOT_FOUND;
            end
            KIND_DEQUEUE: begin
                h = q_head[c.sel];
                if (h >= NIL_LINK) begin
                    r.status = ST_EMPTY;
                end else begin
                    sched_unlink(h);
                    r = entry_fields(h);
                end
            end
            KIND_REQUEUE: begin
                if (!present) begin
                    r.status = ST_NOT_FOUND;
                end else if (linked) begin
                    r = entry_fields(id);
                    r.status = ST_QUEUED;
                end else begin
                    sched_insert(id);
                    r = entry_fields(id);
                end
            end
            KIND_CLEAR: begin
                for (int i = 0; i < NUM_PROCS; i++) begin
                    pt_valid[i] = 0; pt_queued[i] = 0;
                end
                for (int i = 0; i < 4; i++) begin
                    q_head[i] = NIL_LINK; q_tail[i] = NIL_LINK; q_size[i] = 0;
                end
            end
            default: ;
        endcase
        r.count = q_size[c.sel][4:0];
        return r;
    endfunction

    function automatic t_sched_cmd make_cmd(logic [3:0] k, int pid, int prio, int cls, int sel);
        t_sched_cmd c;
        c.kind = k; c.pid = pid[3:0]; c.prio = prio[3:0]; c.cls = cls[3:0]; c.sel = sel[1:0];
        return c;
    endfunction

    function automatic t_sched_cmd rand_cmd();
        t_sched_cmd c;
        int r;
        c.pid = 4'($urandom_range(0, 15));
        c.prio = 4'($urandom_range(0, 15));
        c.cls = 4'($urandom_range(0, 15));
        c.sel = 2'($urandom_range(0, 3));
        r = $urandom_range(0, 99);
        // mostly table operations; rare clears and out-of-range kinds
        if (r < 18)      c.kind = KIND_CREATE;
        else if (r < 95) c.kind = 4'($urandom_range(KIND_BLOCK, KIND_REQUEUE));
        else if (r < 97) c.kind = KIND_CLEAR;
        else             c.kind = 4'($urandom_range(10, 15));
        return c;
    endfunction

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata <= '0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (cmd_q.size() > 0 && (quiet_phase || $urandom_range(0, 99) >= 34)) begin
                t_sched_cmd c;
                c = cmd_q.pop_front();
                expected_results.push_back(sched_apply(c));
                i_s_tvalid <= 1'b1;
                i_s_tdata <= {6'd0, c.sel, c.cls, c.prio, c.pid, c.kind};
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // receiver ready, with one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            hold_cnt <= 0;
        end else if (hold_req && hold_cnt < HOLD_CYCLES) begin
            hold_cnt <= hold_cnt + 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= quiet_phase || ($urandom_range(0, 99) >= 34);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            t_res got;
            t_res exp;
            got.status = o_m_tdata[2:0];
            got.id = o_m_tdata[6:3];
            got.prio = o_m_tdata[10:7];
            got.cls = o_m_tdata[14:11];
            got.blocked = o_m_tdata[15];
            got.suspended = o_m_tdata[16];
            got.count = o_m_tdata[21:17];
            if (expected_results.size() == 0) begin
                $error("unexpected result item %h", o_m_tdata);
                errors++;
            end else begin
                exp = expected_results.pop_front();
                if (got.status !== exp.status) begin
                    $error("status exp %0d got %0d", exp.status, got.status); errors++;
                end
                if (got.id !== exp.id) begin
                    $error("out_id exp %0d got %0d", exp.id, got.id); errors++;
                end
                if (got.prio !== exp.prio) begin
                    $error("out_priority exp %0d got %0d", exp.prio, got.prio); errors++;
                end
                if (got.cls !== exp.cls) begin
                    $error("out_class exp %0d got %0d", exp.cls, got.cls); errors++;
                end
                if (got.blocked !== exp.blocked) begin
                    $error("out_blocked exp %0d got %0d", exp.blocked, got.blocked); errors++;
                end
                if (got.suspended !== exp.suspended) begin
                    $error("out_suspended exp %0d got %0d", exp.suspended, got.suspended);
                    errors++;
                end
                if (got.count !== exp.count) begin
                    $error("queue_count exp %0d got %0d", exp.count, got.count); errors++;
                end
            end
        end
    end

    // watchdog on cycles with no accepted item on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_watch <= 0;
        end else if (stim_done && expected_results.size() == 0) begin
            idle_watch <= 0;
        end else begin
            idle_watch <= idle_watch + 1;
            if (idle_watch >= WATCH_LIMIT) begin
                $display("[process_queue_scheduler_unit] ERROR");
                $finish;
            end
        end
    end

    initial begin
        errors = 0;
        stim_done = 0;
        quiet_phase = 0;
        hold_req = 0;
        idle_watch = 0;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_m_tready = 1'b0;
        sched_reset();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty queues, extremes, every kind and each corner
        cmd_q.push_back(make_cmd(KIND_DEQUEUE, 0, 0, 0, 0));
        cmd_q.push_back(make_cmd(KIND_QUERY, 15, 0, 0, 3));
        cmd_q.push_back(make_cmd(KIND_CREATE, 0, 15, 15, 0));
        cmd_q.push_back(make_cmd(KIND_CREATE, 15, 0, 0, 0));
        cmd_q.push_back(make_cmd(KIND_CREATE, 7, 15, 5, 0));
        cmd_q.push_back(make_cmd(KIND_CREATE, 0, 3, 3, 0));
        cmd_q.push_back(make_cmd(KIND_BLOCK, 15, 0, 0, 1));
        cmd_q.push_back(make_cmd(KIND_BLOCK, 15, 0, 0, 1));
        cmd_q.push_back(make_cmd(KIND_SUSPEND, 15, 0, 0, 3));
        cmd_q.push_back(make_cmd(KIND_SUSPEND, 7, 0, 0, 2));
        cmd_q.push_back(make_cmd(KIND_UNBLOCK, 15, 0, 0, 2));
        cmd_q.push_back(make_cmd(KIND_RESUME, 15, 0, 0, 0));
        cmd_q.push_back(make_cmd(KIND_SET_PRIO, 0, 0, 0, 0));
        cmd_q.push_back(make_cmd(KIND_SET_PRIO, 0, 0, 0, 0));
        cmd_q.push_back(make_cmd(KIND_DEQUEUE, 0, 0, 0, 0));
        cmd_q.push_back(make_cmd(KIND_BLOCK, 15, 0, 0, 0));
        cmd_q.push_back(make_cmd(KIND_REQUEUE, 15, 0, 0, 0));
        cmd_q.push_back(make_cmd(KIND_REQUEUE, 15, 0, 0, 0));
        cmd_q.push_back(make_cmd(KIND_REQUEUE, 3, 0, 0, 0));
        cmd_q.push_back(make_cmd(KIND_DEQUEUE, 0, 0, 0, 2));
        cmd_q.push_back(make_cmd(KIND_DEQUEUE, 0, 0, 0, 0));
        cmd_q.push_back(make_cmd(4'd15, 5, 0, 0, 0));
        cmd_q.push_back(make_cmd(KIND_CLEAR, 0, 0, 0, 0));
        cmd_q.push_back(make_cmd(KIND_QUERY, 0, 0, 0, 0));

        // random: fill the table, then churn it
        for (int i = 0; i < 1600; i++) begin
            if (i % 400 == 0)
                for (int j = 0; j < 12; j++)
                    cmd_q.push_back(make_cmd(KIND_CREATE, $urandom_range(0, 15),
                        $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 3)));
            cmd_q.push_back(rand_cmd());
        end

        // long output hold-off while the input keeps offering items
        wait (cmd_q.size() < 1500);
        @(posedge i_clk);
        hold_req <= 1'b1;
        wait (hold_cnt >= HOLD_CYCLES);
        wait (cmd_q.size() < 800);
        quiet_phase <= 1'b1;
        wait (cmd_q.size() < 600);
        quiet_phase <= 1'b0;

        wait (cmd_q.size() == 0);
        stim_done = 1;
        wait (expected_results.size() == 0);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("[process_queue_scheduler_unit] OK");
        end else begin
            $display("[process_queue_scheduler_unit] ERROR");
        end
        $finish;
    end

endmodule
